/* design/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// csvt_pkg: shared types and constants of the CSV stream tokenizer
// Event codes, delimiter characters and the queued event record.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [2:0] EV_CHAR      = 3'd0;
  localparam logic [2:0] EV_FIELD_END = 3'd1;
  localparam logic [2:0] EV_ROW_END   = 3'd2;
  localparam logic [2:0] EV_ERROR     = 3'd3;
  localparam logic [2:0] EV_DONE      = 3'd4;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       last;
  } event_t;

endpackage

/* design/csv_stream_tokenizer.sv */
// ----------------------------------------------------------------------------
// csv_stream_tokenizer: streaming CSV tokenizer
// Decodes CSV text into field character, field end, row end, error and done
// events.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one byte of text per transaction, or an
// end marker (end_of_input = 1) that closes the text. Output channel
// (out_valid/out_ready): one event per transaction; last_of_run flags the
// final event caused by an input transaction. One input can cause up to
// three events, or none.
// The parser state is updated in the cycle an input is accepted and its
// events are written into a four-entry event queue, whose oldest entry is
// offered on the output. Throughput: one input per cycle while each input
// yields at most one event and the receiver takes one per cycle. The output
// drains one event per cycle while out_ready is high. in_ready is high while
// the queue holds at most one event, so it depends on queue fill only, not on
// out_ready: a waiting result does not block the next input as long as room
// for three events remains.
// When the receiver stalls the queue fills and in_ready drops until room is
// back. Reset clears the parser state and empties the queue. An end marker
// returns the parser to its reset state for the next text.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] char_out,
  output logic       last_of_run
);

  typedef enum logic [2:0] {
    PH_ROW_START   = 3'd0,
    PH_AFTER_COMMA = 3'd1,
    PH_UNQUOTED    = 3'd2,
    PH_IN_QUOTE    = 3'd3,
    PH_QUOTE_SEEN  = 3'd4,
    PH_AFTER_CLOSE = 3'd5,
    PH_ERROR       = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic       blank, blank_next;
  logic       seen, seen_next;

  event_t     queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       in_acc, out_acc;
  logic [1:0] grp_n;
  logic [2:0] grp_kind [3];
  logic [7:0] grp_ch;

  logic is_blank, is_comma, is_nl, is_quote;

  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign is_comma = (in_byte == CH_COMMA);
  assign is_nl    = (in_byte == CH_NEWLINE);
  assign is_quote = (in_byte == CH_QUOTE);

  assign in_ready  = (count <= 3'd1);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign out_acc   = out_valid && out_ready;

  assign event_kind  = queue[rd_ptr].kind;
  assign char_out    = queue[rd_ptr].ch;
  assign last_of_run = queue[rd_ptr].last;

  // Parser: next state and the group of events for the current input.
  // A character event only ever lands in the first slot.
  always_comb begin
    phase_next  = phase;
    blank_next  = blank;
    seen_next   = seen;
    grp_n       = 2'd0;
    grp_kind[0] = EV_CHAR;
    grp_kind[1] = EV_CHAR;
    grp_kind[2] = EV_CHAR;
    grp_ch      = in_byte;
    if (end_of_input) begin
      phase_next = PH_ROW_START;
      blank_next = 1'b0;
      seen_next  = 1'b0;
      unique case (phase)
        PH_ROW_START: begin
          if (blank) begin
            grp_n       = 2'd3;
            grp_kind[0] = EV_FIELD_END;
            grp_kind[1] = EV_ROW_END;
            grp_kind[2] = EV_DONE;
          end else begin
            grp_n       = 2'd1;
            grp_kind[0] = seen ? EV_DONE : EV_ERROR;
          end
        end
        PH_AFTER_COMMA: begin
          if (blank) begin
            grp_n       = 2'd3;
            grp_kind[0] = EV_FIELD_END;
            grp_kind[1] = EV_ROW_END;
            grp_kind[2] = EV_DONE;
          end else begin
            grp_n       = 2'd2;
            grp_kind[0] = EV_ROW_END;
            grp_kind[1] = EV_DONE;
          end
        end
        PH_UNQUOTED, PH_QUOTE_SEEN, PH_AFTER_CLOSE: begin
          grp_n       = 2'd3;
          grp_kind[0] = EV_FIELD_END;
          grp_kind[1] = EV_ROW_END;
          grp_kind[2] = EV_DONE;
        end
        default: begin
          grp_n       = 2'd1;
          grp_kind[0] = EV_ERROR;
        end
      endcase
    end else begin
      seen_next = 1'b1;
      unique case (phase)
        PH_ROW_START, PH_AFTER_COMMA: begin
          priority if (is_blank) begin
            blank_next = 1'b1;
          end else if (is_comma) begin
            grp_n       = 2'd1;
            grp_kind[0] = EV_FIELD_END;
            phase_next  = PH_AFTER_COMMA;
            blank_next  = 1'b0;
          end else if (is_nl) begin
            // blanks before the newline make an empty field
            if (blank) begin
              grp_n       = 2'd2;
              grp_kind[0] = EV_FIELD_END;
              grp_kind[1] = EV_ROW_END;
            end else begin
              grp_n       = 2'd1;
              grp_kind[0] = EV_ROW_END;
            end
            phase_next = PH_ROW_START;
            blank_next = 1'b0;
          end else if (is_quote) begin
            phase_next = PH_IN_QUOTE;
            blank_next = 1'b0;
          end else begin
            grp_n      = 2'd1;
            phase_next = PH_UNQUOTED;
            blank_next = 1'b0;
          end
        end
        PH_UNQUOTED: begin
          priority if (is_comma) begin
            grp_n       = 2'd1;
            grp_kind[0] = EV_FIELD_END;
            phase_next  = PH_AFTER_COMMA;
          end else if (is_nl) begin
            grp_n       = 2'd2;
            grp_kind[0] = EV_FIELD_END;
            grp_kind[1] = EV_ROW_END;
            phase_next  = PH_ROW_START;
          end else begin
            grp_n = 2'd1;
          end
        end
        PH_IN_QUOTE: begin
          if (is_quote) begin
            phase_next = PH_QUOTE_SEEN;
          end else begin
            grp_n = 2'd1;
          end
        end
        PH_QUOTE_SEEN, PH_AFTER_CLOSE: begin
          // doubled quote only counts right after a quote
          priority if (is_quote && (phase == PH_QUOTE_SEEN)) begin
            grp_n      = 2'd1;
            phase_next = PH_IN_QUOTE;
          end else if (is_blank) begin
            phase_next = PH_AFTER_CLOSE;
          end else if (is_comma) begin
            grp_n       = 2'd1;
            grp_kind[0] = EV_FIELD_END;
            phase_next  = PH_AFTER_COMMA;
          end else if (is_nl) begin
            grp_n       = 2'd2;
            grp_kind[0] = EV_FIELD_END;
            grp_kind[1] = EV_ROW_END;
            phase_next  = PH_ROW_START;
          end else begin
            grp_n       = 2'd1;
            grp_kind[0] = EV_ERROR;
            phase_next  = PH_ERROR;
          end
        end
        default: begin
          // error phase swallows bytes until the end marker
          phase_next = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_ROW_START;
      blank  <= 1'b0;
      seen   <= 1'b0;
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (in_acc) begin
        phase  <= phase_next;
        blank  <= blank_next;
        seen   <= seen_next;
        wr_ptr <= wr_ptr + grp_n;
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (in_acc ? {1'b0, grp_n} : 3'd0) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < grp_n) begin
          queue[wr_ptr + 2'(i)].kind <= grp_kind[i];
          queue[wr_ptr + 2'(i)].ch   <= (grp_kind[i] == EV_CHAR) ? grp_ch : 8'd0;
          queue[wr_ptr + 2'(i)].last <= (2'(i) == grp_n - 2'd1);
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("event queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (in_acc && end_of_input) |=> (phase == PH_ROW_START) && !blank && !seen)
    else $error("end marker did not return parser to reset state");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |=> (phase == PH_ERROR) || (phase == PH_ROW_START))
    else $error("error phase left without end marker");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd0 && !in_acc) |=> !out_valid)
    else $error("output valid with empty queue");

endmodule
